>>> rtl/ctw_pkg.sv
package ctw_pkg;

  // field widths
  localparam int PIX_W  = 8;
  localparam int CODE_W = 32;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int WID_W  = 12;
  localparam int HGT_W  = 13;

  // configuration register index, taken from paddr[2]
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // reset values of the size registers
  localparam logic [WID_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;

  // largest effective frame height
  localparam logic [HGT_W-1:0] HEIGHT_MAX = 13'd4096;

  // line memory control from the pipeline
  typedef struct packed {
    logic push;    // item accepted: read the column at addr_i
    logic commit;  // stage two retires: write back the shifted column
  } lb_ctl_t;

endpackage

>>> rtl/census_transform_window_top.sv
// Streaming census transform over a WIN_W x WIN_H window of 8-bit grey pixels in raster
// order. One item is taken per clock unless back-pressure holds the output, and one result
// leaves per item, in order. Stage one reads the column of buffered lines from the line
// memory, stage two shifts the window, forms the code and writes the aged column back,
// with the written word forwarded when the next pixel reads the same column. An output
// register holds a result under back-pressure while one more item waits in stage two.
// The line memory holds MAX_WIDTH words of (WIN_H-1) pixels and is not cleared after
// reset: codes whose window reaches into lines not yet written are undefined. Results for
// windows not fully inside the image, and for the first WIN_H-1 rows and WIN_W-1 columns,
// carry inside_res 0 with code, center_row and center_col 0. The size registers sit at
// byte 0 (width) and 4 (height); write them only while the block is idle.
module census_transform_window_top
  import ctw_pkg::*;
#(
  parameter int WIN_W     = 5,
  parameter int WIN_H     = 5,
  parameter int MAX_WIDTH = 2048
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic              frame_start_i,
  // code output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CODE_W-1:0] code_o,
  output logic [ROW_W-1:0]  center_row_o,
  output logic [COL_W-1:0]  center_col_o,
  output logic              inside_res_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int COLUMN_W  = WIN_H * PIX_W;
  localparam int OFF_X     = (WIN_W - 1) / 2;
  localparam int OFF_Y     = (WIN_H - 1) / 2;
  localparam int COL_LIMIT = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;

  localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(WIN_H - 1);
  localparam logic [COL_W-1:0] COL_FIRST = COL_W'(WIN_W - 1);
  localparam logic [ROW_W-1:0] ROW_BACK  = ROW_W'(WIN_H - 1 - OFF_Y);
  localparam logic [COL_W-1:0] COL_BACK  = COL_W'(WIN_W - 1 - OFF_X);
  localparam logic [WID_W-1:0] WID_MAX   = WID_W'(COL_LIMIT);

  // configuration registers
  logic [WID_W-1:0] frame_width_q;
  logic [HGT_W-1:0] frame_height_q;
  logic             cfg_wr;

  // position counters
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;

  // stage two
  logic             s1_valid_q;
  logic             s1_inside_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_go;

  // output register
  logic              out_valid_q;
  logic [CODE_W-1:0] code_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic              out_inside_q;

  logic                in_fire;
  logic [WID_W-1:0]    w_eff;
  logic [HGT_W-1:0]    h_eff;
  logic [ROW_W-1:0]    r0;
  logic [COL_W-1:0]    c0;
  logic                win_inside;
  logic [WID_W-1:0]    c_next;
  logic [HGT_W-1:0]    r_next;
  logic [AW+COL_W-1:0] addr_ext;
  logic [AW-1:0]       addr;
  lb_ctl_t             lb_ctl;
  logic [COLUMN_W-1:0] column;
  logic [CODE_W-1:0]   code;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = 32'(frame_width_q);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[WID_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[HGT_W-1:0];
        default:          ;
      endcase
    end
  end

  // effective frame size
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (frame_width_q > WID_MAX) begin
      w_eff = WID_MAX;
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = HGT_W'(1);
    end else if (frame_height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = frame_height_q;
    end
  end

  // handshake: stage two retires when the output register is free or being taken
  assign s1_go      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_fire    = in_valid_i && in_ready_o;

  // position of the accepted pixel and next position
  assign r0 = frame_start_i ? '0 : row_q;
  assign c0 = frame_start_i ? '0 : col_q;
  assign win_inside = (r0 >= ROW_FIRST) && (c0 >= COL_FIRST) &&
                      ({1'b0, r0} < h_eff) && ({1'b0, c0} < w_eff);

  always_comb begin
    c_next = {1'b0, c0} + WID_W'(1);
    r_next = {1'b0, r0};
    if (c_next >= w_eff) begin
      c_next = '0;
      r_next = {1'b0, r0} + HGT_W'(1);
      if (r_next >= h_eff) begin
        r_next = '0;
      end
    end
    col_d = c_next[COL_W-1:0];
    row_d = r_next[ROW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_fire) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // line memory column address
  assign addr_ext = {{AW{1'b0}}, c0};
  assign addr     = addr_ext[AW-1:0];

  assign lb_ctl.push   = in_fire;
  assign lb_ctl.commit = s1_go;

  ctw_line_buf #(
    .WIN_H     (WIN_H),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (lb_ctl),
    .addr_i   (addr),
    .pixel_i  (pixel_i),
    .column_o (column)
  );

  ctw_window #(
    .WIN_W (WIN_W),
    .WIN_H (WIN_H)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_go),
    .column_i (column),
    .code_o   (code)
  );

  // stage two control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // stage two payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_inside_q <= win_inside;
      s1_row_q    <= win_inside ? (r0 - ROW_BACK) : '0;
      s1_col_q    <= win_inside ? (c0 - COL_BACK) : '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      code_q       <= s1_inside_q ? code : '0;
      out_row_q    <= s1_row_q;
      out_col_q    <= s1_col_q;
      out_inside_q <= s1_inside_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_o       = code_q;
  assign center_row_o = out_row_q;
  assign center_col_o = out_col_q;
  assign inside_res_o = out_inside_q;

  // an accepted item is in stage two on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> s1_valid_q)
    else $error("accepted item missing from stage two");

  // a held result blocks stage two
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !s1_go)
    else $error("stage two overwrote a held result");

  // a stalled result keeps its code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(code_q))
    else $error("held result changed");

  // border results carry zero code and position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_inside_q |-> code_q == '0 && out_row_q == '0 && out_col_q == '0)
    else $error("border result not cleared");

endmodule

>>> rtl/ctw_line_buf.sv
module ctw_line_buf
  import ctw_pkg::*;
#(
  parameter int WIN_H     = 5,
  parameter int MAX_WIDTH = 2048,
  localparam int AW       = $clog2(MAX_WIDTH),
  localparam int WORD_W   = (WIN_H - 1) * PIX_W,
  localparam int COLUMN_W = WIN_H * PIX_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lb_ctl_t             ctl_i,
  input  logic [AW-1:0]       addr_i,
  input  logic [PIX_W-1:0]    pixel_i,
  output logic [COLUMN_W-1:0] column_o
);

  // one word per column: row k of the buffered lines at bits [8k +: 8], row 0 newest
  logic [WORD_W-1:0] mem [MAX_WIDTH];

  logic [WORD_W-1:0] rdata_q;
  logic [WORD_W-1:0] fwd_data_q;
  logic              fwd_hit_q;
  logic [AW-1:0]     addr_q;
  logic [PIX_W-1:0]  pixel_q;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;
  logic              hit;

  // a read colliding with the write of the previous item takes the written word
  assign hit     = ctl_i.push && ctl_i.commit && (addr_i == addr_q);
  assign rd_word = fwd_hit_q ? fwd_data_q : rdata_q;

  // lines age by one row, the new pixel enters the newest row
  generate
    if (WIN_H > 2) begin : g_shift
      assign wr_word = {rd_word[(WIN_H-2)*PIX_W-1:0], pixel_q};
    end else begin : g_single
      assign wr_word = pixel_q;
    end
  endgenerate

  // column top to bottom: oldest line first, new pixel last
  always_comb begin
    column_o = '0;
    for (int a = 0; a < WIN_H - 1; a++) begin
      column_o[a*PIX_W +: PIX_W] = rd_word[(WIN_H-2-a)*PIX_W +: PIX_W];
    end
    column_o[(WIN_H-1)*PIX_W +: PIX_W] = pixel_q;
  end

  // line memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit) begin
      mem[addr_q] <= wr_word;
    end
    if (ctl_i.push) begin
      rdata_q <= mem[addr_i];
    end
  end

  // item payload held with the read data
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      addr_q     <= addr_i;
      pixel_q    <= pixel_i;
      fwd_data_q <= wr_word;
    end
  end

  // forwarding flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (ctl_i.push) begin
      fwd_hit_q <= hit;
    end
  end

endmodule

>>> rtl/ctw_window.sv
module ctw_window
  import ctw_pkg::*;
#(
  parameter int WIN_W     = 5,
  parameter int WIN_H     = 5,
  localparam int COLUMN_W = WIN_H * PIX_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                shift_i,
  input  logic [COLUMN_W-1:0] column_i,
  output logic [CODE_W-1:0]   code_o
);

  localparam int OFF_X = (WIN_W - 1) / 2;
  localparam int OFF_Y = (WIN_H - 1) / 2;
  localparam int NB    = WIN_W * WIN_H - 1;
  localparam int CIDX  = OFF_Y * WIN_W + OFF_X;

  logic [PIX_W-1:0]     win_q [WIN_H][WIN_W];
  logic [PIX_W-1:0]     win_d [WIN_H][WIN_W];
  logic [PIX_W-1:0]     ctr;
  logic [NB-1:0]        bits;
  logic [NB+CODE_W-1:0] bits_ext;

  // window moves one column left, new column enters at the right
  always_comb begin
    for (int a = 0; a < WIN_H; a++) begin
      for (int b = 0; b < WIN_W - 1; b++) begin
        win_d[a][b] = win_q[a][b+1];
      end
      win_d[a][WIN_W-1] = column_i[a*PIX_W +: PIX_W];
    end
  end

  // neighbors against center, row-major, last neighbor in the lsb
  assign ctr = win_d[OFF_Y][OFF_X];
  always_comb begin
    bits = '0;
    for (int a = 0; a < WIN_H; a++) begin
      for (int b = 0; b < WIN_W; b++) begin
        if (a * WIN_W + b < CIDX) begin
          bits[NB-1-(a*WIN_W+b)] = (win_d[a][b] < ctr);
        end else if (a * WIN_W + b > CIDX) begin
          bits[NB-(a*WIN_W+b)] = (win_d[a][b] < ctr);
        end
      end
    end
  end

  // keep the low 32 bits
  assign bits_ext = {{CODE_W{1'b0}}, bits};
  assign code_o   = bits_ext[CODE_W-1:0];

  // window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < WIN_H; a++) begin
        for (int b = 0; b < WIN_W; b++) begin
          win_q[a][b] <= '0;
        end
      end
    end else if (shift_i) begin
      win_q <= win_d;
    end
  end

endmodule

>>> tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ctw_pkg::*;

  localparam int WIN_W     = 5;
  localparam int WIN_H     = 5;
  localparam int MAX_WIDTH = 2048;
  localparam int MID_X     = (WIN_W - 1) / 2;
  localparam int MID_Y     = (WIN_H - 1) / 2;
  localparam int COL_SPAN  = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
  localparam longint CYCLE_LIMIT = 10_000_000;
  localparam int MAX_REPORTS = 100;
  localparam int LONG_HOLD   = 120;

  // one census result as it leaves the block
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              in_image;
  } census_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [PIX_W-1:0]  pixel_i = '0;
  logic              frame_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CODE_W-1:0] code_o;
  logic [ROW_W-1:0]  center_row_o;
  logic [COL_W-1:0]  center_col_o;
  logic              inside_res_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // shadow of the block: line memory, window, position and size registers
  logic [PIX_W-1:0] line_mem [WIN_H-1][MAX_WIDTH];
  logic [PIX_W-1:0] win_px [WIN_H][WIN_W];
  int unsigned      pos_row;
  int unsigned      pos_col;
  logic [WID_W-1:0] cfg_width;
  logic [HGT_W-1:0] cfg_height;

  census_res_t expected_codes[$];
  int     mismatches = 0;
  int     items_sent = 0;
  longint cycles = 0;
  bit     tx_idle_en = 1'b1;
  bit     rx_idle_en = 1'b1;
  bit     rx_hold_req = 1'b0;
  int     rx_stall = 0;

  census_transform_window_top #(
    .WIN_W    (WIN_W),
    .WIN_H    (WIN_H),
    .MAX_WIDTH(MAX_WIDTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_o       (code_o),
    .center_row_o (center_row_o),
    .center_col_o (center_col_o),
    .inside_res_o (inside_res_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // sizes as the block uses them
  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > COL_SPAN) return COL_SPAN;
    return 32'(cfg_width);
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height == 0) return 1;
    if (cfg_height > HEIGHT_MAX) return 32'(HEIGHT_MAX);
    return 32'(cfg_height);
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // random grey value
  function automatic logic [PIX_W-1:0] rand_px();
    return PIX_W'($urandom_range(0, 255));
  endfunction

  // census code of the window ending at this pixel, advances the shadow state
  function automatic census_res_t census_predict(input logic [PIX_W-1:0] px,
                                                 input logic fs);
    census_res_t res;
    int unsigned w, h, r, c, addr;
    int a, b;
    logic [PIX_W-1:0] column [WIN_H];
    logic [PIX_W-1:0] ctr;
    res = '0;
    w = eff_width();
    h = eff_height();
    if (fs) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    addr = c % MAX_WIDTH;
    // oldest buffered line on top, new pixel at the bottom
    for (a = 0; a < WIN_H - 1; a++) column[a] = line_mem[WIN_H-2-a][addr];
    column[WIN_H-1] = px;
    for (a = WIN_H - 2; a > 0; a--) line_mem[a][addr] = line_mem[a-1][addr];
    line_mem[0][addr] = px;
    for (a = 0; a < WIN_H; a++) begin
      for (b = 0; b < WIN_W - 1; b++) win_px[a][b] = win_px[a][b+1];
      win_px[a][WIN_W-1] = column[a];
    end
    // full window inside the image: one bit per neighbor, center skipped
    if (r >= WIN_H - 1 && c >= WIN_W - 1 && r < h && c < w) begin
      ctr = win_px[MID_Y][MID_X];
      for (a = 0; a < WIN_H; a++) begin
        for (b = 0; b < WIN_W; b++) begin
          if (!(a == MID_Y && b == MID_X))
            res.code = {res.code[CODE_W-2:0], win_px[a][b] < ctr};
        end
      end
      res.row = ROW_W'(r - (WIN_H - 1) + MID_Y);
      res.col = COL_W'(c - (WIN_W - 1) + MID_X);
      res.in_image = 1'b1;
    end
    // raster advance with wrap at the effective sizes
    c = c + 1;
    if (c >= w) begin
      c = 0;
      r = r + 1;
      if (r >= h) r = 0;
    end
    pos_col = c & 32'h7FF;
    pos_row = r & 32'hFFF;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $error("%s: expected %0h, got %0h", field, want, got);
  endtask

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk_i) begin
    if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_stall = LONG_HOLD;
    end else if (rx_stall > 0) begin
      rx_stall--;
    end else if (rx_idle_en) begin
      rx_stall = idle_len();
    end
    out_ready_i <= (rx_stall == 0);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    census_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $error("result with no item waiting: code %0h", code_o);
      end else begin
        want = expected_codes.pop_front();
        if (code_o !== want.code) report_mismatch("code", want.code, code_o);
        if (center_row_o !== want.row)
          report_mismatch("center_row", 32'(want.row), 32'(center_row_o));
        if (center_col_o !== want.col)
          report_mismatch("center_col", 32'(want.col), 32'(center_col_o));
        if (inside_res_o !== want.in_image)
          report_mismatch("inside_res", 32'(want.in_image), 32'(inside_res_o));
      end
    end
  end

  // offer one item after a random gap, wait for it to be taken
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int gap;
    gap = tx_idle_en ? idle_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= px;
    frame_start_i <= fs;
    do @(posedge clk_i); while (!in_ready_o);
    expected_codes.insert(expected_codes.size(), census_predict(px, fs));
    items_sent++;
  endtask

  // stop offering items until every result is back
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
  endtask

  // one register transfer: setup, access, then idle
  task automatic apb_access(input logic idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_size_reg(input logic idx, input logic [31:0] want);
    logic [31:0] got;
    apb_access(idx, 1'b0, '0, got);
    if (got !== want)
      report_mismatch(idx == REG_FRAME_WIDTH ? "width register" : "height register",
                      want, got);
  endtask

  // drain, then write both size registers and read them back
  task automatic set_sizes(input logic [31:0] wval, input logic [31:0] hval);
    logic [31:0] unused;
    wait_results_drained();
    apb_access(REG_FRAME_WIDTH, 1'b1, wval, unused);
    cfg_width = wval[WID_W-1:0];
    check_size_reg(REG_FRAME_WIDTH, 32'(cfg_width));
    apb_access(REG_FRAME_HEIGHT, 1'b1, hval, unused);
    cfg_height = hval[HGT_W-1:0];
    check_size_reg(REG_FRAME_HEIGHT, 32'(cfg_height));
  endtask

  task automatic test_register_reset();
    check_size_reg(REG_FRAME_WIDTH, 32'(WIDTH_RESET));
    check_size_reg(REG_FRAME_HEIGHT, 32'(HEIGHT_RESET));
  endtask

  // smallest full frame: only the last pixel closes a window, center is white
  task automatic test_directed_window();
    int i;
    logic [PIX_W-1:0] px;
    set_sizes(5, 5);
    for (i = 0; i < 25; i++) begin
      if (i == 12) px = 8'hFF;
      else if (i % 5 == 0) px = 8'h00;
      else px = PIX_W'(i * 37);
      send_pixel(px, i == 0);
    end
  endtask

  // zero and too small sizes never give a full window
  task automatic test_degenerate_sizes();
    int i;
    set_sizes(0, 0);
    for (i = 0; i < 6; i++) send_pixel(rand_px(), i == 0);
    set_sizes(4, 8191);
    for (i = 0; i < 9; i++) send_pixel(rand_px(), i == 0);
    set_sizes(5, 4);
    for (i = 0; i < 9; i++) send_pixel(rand_px(), i == 0);
  endtask

  // sizes cut below the current position: counters wrap on their own
  task automatic test_shrink_wrap();
    int i;
    set_sizes(9, 12);
    for (i = 0; i < 5 * 9 + 7; i++) send_pixel(rand_px(), i == 0);
    set_sizes(6, 12);
    for (i = 0; i < 40; i++) send_pixel(rand_px(), 1'b0);
    set_sizes(6, 5);
    for (i = 0; i < 40; i++) send_pixel(rand_px(), 1'b0);
  endtask

  // receiver holds off while items keep coming, so the block fills up
  task automatic test_backpressure();
    int i;
    set_sizes(8, 6);
    tx_idle_en = 1'b0;
    rx_hold_req = 1'b1;
    for (i = 0; i < 48; i++) send_pixel(rand_px(), i == 0);
    tx_idle_en = 1'b1;
  endtask

  // random frames under random sizes, with cut frames and stray frame starts
  task automatic test_random_frames(input int n_items);
    int first, phase, frames, f, len, i, base;
    int unsigned nw, nh;
    bit shrink, restart, palette;
    logic [PIX_W-1:0] px;
    first = items_sent;
    phase = 0;
    while (items_sent - first < n_items) begin
      phase++;
      tx_idle_en = (phase % 4 != 3);
      rx_idle_en = (phase % 4 != 3);
      shrink = (phase > 1) && ($urandom_range(0, 3) == 0);
      if (shrink) begin
        nw = $urandom_range(1, eff_width());
        nh = $urandom_range(1, eff_height());
      end else if ($urandom_range(0, 9) == 0) begin
        nw = $urandom_range(0, 4);
        nh = $urandom_range(0, 12);
      end else begin
        nw = $urandom_range(5, 14);
        nh = $urandom_range(5, 10);
      end
      // junk above the register width is dropped by the block
      set_sizes(($urandom() & 32'hFFFF_F000) | nw, ($urandom() & 32'hFFFF_E000) | nh);
      frames = $urandom_range(1, 3);
      for (f = 0; f < frames; f++) begin
        restart = (f == 0) ? !shrink : ($urandom_range(0, 3) != 0);
        palette = ($urandom_range(0, 2) == 0);
        base = $urandom_range(0, 252);
        len = eff_width() * eff_height();
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, len);
        for (i = 0; i < len; i++) begin
          px = palette ? PIX_W'(base + $urandom_range(0, 3)) : rand_px();
          send_pixel(px, (i == 0 && restart) || ($urandom_range(0, 49) == 0));
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // widest frame setting: width beyond the limit saturates, border results only
  task automatic test_wide_frame();
    int i;
    set_sizes(4095, 5);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (i = 0; i < 40; i++) send_pixel(rand_px(), i == 0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // tallest frame setting: height saturates, full windows still close
  task automatic test_tall_frame();
    int i;
    set_sizes(8191, 8191);
    set_sizes(5, 8191);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (i = 0; i < 5 * 7; i++) send_pixel(rand_px(), i == 0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    int a, b;
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    pos_row = 0;
    pos_col = 0;
    for (a = 0; a < WIN_H - 1; a++)
      for (b = 0; b < MAX_WIDTH; b++) line_mem[a][b] = '0;
    for (a = 0; a < WIN_H; a++)
      for (b = 0; b < WIN_W; b++) win_px[a][b] = '0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_directed_window();
    test_degenerate_sizes();
    test_shrink_wrap();
    test_backpressure();
    test_random_frames(400);
    test_wide_frame();
    test_tall_frame();

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> census_transform_window_top.f
rtl/ctw_pkg.sv
rtl/ctw_line_buf.sv
rtl/ctw_window.sv
rtl/census_transform_window_top.sv
tb/testbench.sv
